FILE: sv/vfld_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfld_pkg
// Shared types, constants and helpers of the vertex format layout decoder.
// ----------------------------------------------------------------------------
package vfld_pkg;

    localparam int SLOT_COUNT  = 21;
    localparam int FLAGS_W     = 21;
    localparam int COUNT_W     = 32;
    localparam int SLOT_W      = 5;
    localparam int OFFSET_W    = 6;
    localparam int STRIDE_W    = 8;
    localparam int BYTES_W     = 40;
    localparam int WIDTH_W     = 2;

    localparam logic [OFFSET_W-1:0] POSITION_FLOATS = 6'd3;

    // Component widths by flag bit (bit n is slot n+1)
    localparam logic [FLAGS_W-1:0] WIDTH1_BITS = 21'h0003BF;
    localparam logic [FLAGS_W-1:0] WIDTH2_BITS = 21'h07F800;
    localparam logic [FLAGS_W-1:0] WIDTH3_BITS = 21'h180440;

    typedef logic [SLOT_COUNT:1] vfld_mask_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_START,
        ST_WALK
    } vfld_state_t;

    // One decoded item as handed to the slot walker
    typedef struct packed {
        vfld_mask_t            mask;
        logic [OFFSET_W-1:0]   float_count;
        logic [STRIDE_W-1:0]   stride;
        logic [BYTES_W-1:0]    byte_count;
        logic                  fits;
    } vfld_item_t;

    typedef struct packed {
        logic start;
    } vfld_walk_ctrl_t;

    typedef struct packed {
        logic busy;
        logic free;
    } vfld_walk_stat_t;

    function automatic logic [WIDTH_W-1:0] slot_width(input logic [SLOT_W-1:0] slot);
        logic [WIDTH_W-1:0] w;
        case (slot) inside
            5'd7, 5'd11, 5'd20, 5'd21: w = 2'd3;
            [5'd12:5'd19]:             w = 2'd2;
            default:                   w = 2'd1;
        endcase
        return w;
    endfunction

    // Colour and texture groups only count as an unbroken run from their low bit
    function automatic vfld_mask_t present_mask(input logic [FLAGS_W-1:0] flags);
        logic [FLAGS_W-1:0] m;
        m = flags;
        for (int i = 2; i <= 4; i++) begin
            m[i] = m[i-1] & flags[i];
        end
        for (int i = 12; i <= 18; i++) begin
            m[i] = m[i-1] & flags[i];
        end
        return m;
    endfunction

    function automatic logic [OFFSET_W-1:0] float_total(input vfld_mask_t mask);
        logic [OFFSET_W-1:0] c1;
        logic [OFFSET_W-1:0] c2;
        logic [OFFSET_W-1:0] c3;
        c1 = OFFSET_W'($countones(mask & WIDTH1_BITS));
        c2 = OFFSET_W'($countones(mask & WIDTH2_BITS));
        c3 = OFFSET_W'($countones(mask & WIDTH3_BITS));
        return POSITION_FLOATS + c1 + {c2[OFFSET_W-2:0], 1'b0}
             + {c3[OFFSET_W-2:0], 1'b0} + c3;
    endfunction

endpackage
`default_nettype wire

FILE: sv/vertex_format_layout_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_format_layout_decoder
// Decodes a vertex component flag word into per-slot float offsets, vertex
// stride and buffer size.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready): one transfer carries a 21-bit component
//   flag word and a 32-bit vertex count. Output channel (m_valid/m_ready):
//   each input transfer yields 21 result transfers, slots 1..21 in order,
//   m_last set on slot 21. Each result gives the slot's float offset, whether
//   this item placed it, and the stride, float count, byte count and fits
//   flag of the whole item.
//   Path: an input passes the sum, multiply and start states, the walk and
//   the pending and output registers. Results follow at one per cycle while
//   m_ready stays high. The slot walk over the single-port offset memory,
//   one slot per cycle while m_ready holds high, bounds the item rate, with
//   the sum and multiply states ahead of it.
//   Reset (aresetn low, synchronous): offsets of all slots read as zero until
//   placed; no clearing pass is needed, per-slot written bits cover it.
//   Stall: results sit in an output register; a stalled m_ready holds the
//   walk, and the next input is taken while results of the last item drain.
// ----------------------------------------------------------------------------
module vertex_format_layout_decoder (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [vfld_pkg::FLAGS_W-1:0]  s_component_flags,
    input  wire logic [vfld_pkg::COUNT_W-1:0]  s_vertex_count,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [vfld_pkg::SLOT_W-1:0]        m_slot,
    output logic [vfld_pkg::OFFSET_W-1:0]      m_offset,
    output logic                               m_present,
    output logic [vfld_pkg::STRIDE_W-1:0]      m_stride,
    output logic [vfld_pkg::OFFSET_W-1:0]      m_float_count,
    output logic [vfld_pkg::BYTES_W-1:0]       m_byte_count,
    output logic                               m_fits,
    output logic                               m_last
);
    import vfld_pkg::*;

    vfld_state_t          state_reg;
    vfld_state_t          state_next;
    vfld_mask_t           mask_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [OFFSET_W-1:0]  float_count_reg;
    logic [BYTES_W-1:0]   byte_count_reg;
    logic [STRIDE_W-1:0]  stride;
    logic [BYTES_W-1:0]   product;

    vfld_walk_ctrl_t      walk_ctrl;
    vfld_walk_stat_t      walk_stat;
    vfld_item_t           item;

    assign stride  = {float_count_reg, 2'b00};
    // 8 x 32 multiply, operands zero-extended to 40 bits
    assign product = BYTES_W'(stride) * BYTES_W'(count_reg);

    assign item.mask        = mask_reg;
    assign item.float_count = float_count_reg;
    assign item.stride      = stride;
    assign item.byte_count  = byte_count_reg;
    assign item.fits        = (byte_count_reg[BYTES_W-1:COUNT_W] == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        s_ready         = 1'b0;
        walk_ctrl.start = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_START;
            end
            ST_START: begin
                // hand over once the previous walk has left the pending stage
                walk_ctrl.start = 1'b1;
                if (walk_stat.free) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (!walk_stat.busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // item datapath: run masking at the transfer, then sum, then multiply
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            mask_reg  <= present_mask(s_component_flags);
            count_reg <= s_vertex_count;
        end
        if (state_reg == ST_SUM) begin
            float_count_reg <= float_total(mask_reg);
        end
        if (state_reg == ST_MUL) begin
            byte_count_reg <= product;
        end
    end

    vfld_walk u_walk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (walk_ctrl),
        .item          (item),
        .stat          (walk_stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_slot        (m_slot),
        .m_offset      (m_offset),
        .m_present     (m_present),
        .m_stride      (m_stride),
        .m_float_count (m_float_count),
        .m_byte_count  (m_byte_count),
        .m_fits        (m_fits),
        .m_last        (m_last)
    );

endmodule
`default_nettype wire

FILE: sv/vfld_walk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfld_walk
// Walks slots 1..21 over the offset memory, one slot per cycle while m_ready
// does not hold it back, and drives the registered result channel.
// ----------------------------------------------------------------------------
module vfld_walk (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire vfld_pkg::vfld_walk_ctrl_t    ctrl,
    input  wire vfld_pkg::vfld_item_t         item,
    output vfld_pkg::vfld_walk_stat_t         stat,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [vfld_pkg::SLOT_W-1:0]       m_slot,
    output logic [vfld_pkg::OFFSET_W-1:0]     m_offset,
    output logic                              m_present,
    output logic [vfld_pkg::STRIDE_W-1:0]     m_stride,
    output logic [vfld_pkg::OFFSET_W-1:0]     m_float_count,
    output logic [vfld_pkg::BYTES_W-1:0]      m_byte_count,
    output logic                              m_fits,
    output logic                              m_last
);
    import vfld_pkg::*;

    // offset memory, entry 0 unused
    logic [OFFSET_W-1:0] mem [0:SLOT_COUNT];
    logic [OFFSET_W-1:0] rdata_reg;
    vfld_mask_t          written_reg;

    vfld_item_t          item_reg;
    logic                walking_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [OFFSET_W-1:0] next_off_reg;

    logic                pend_valid_reg;
    logic [SLOT_W-1:0]   pend_slot_reg;
    logic                pend_present_reg;
    logic                pend_written_reg;
    logic [OFFSET_W-1:0] pend_off_reg;

    logic                out_valid_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic                out_present_reg;
    logic [STRIDE_W-1:0] out_stride_reg;
    logic [OFFSET_W-1:0] out_float_reg;
    logic [BYTES_W-1:0]  out_bytes_reg;
    logic                out_fits_reg;
    logic                out_last_reg;

    logic                load_now;
    logic                issue;
    logic                cur_present;
    logic                start_ok;
    logic [OFFSET_W-1:0] pend_offset;

    assign load_now    = pend_valid_reg && (!out_valid_reg || m_ready);
    assign issue       = walking_reg && (!pend_valid_reg || load_now);
    assign cur_present = item_reg.mask[slot_reg];
    assign start_ok    = !walking_reg && !pend_valid_reg;
    assign pend_offset = pend_present_reg ? pend_off_reg :
                         (pend_written_reg ? rdata_reg : '0);

    assign stat.busy = walking_reg;
    assign stat.free = start_ok;

    always_ff @(posedge aclk) begin
        if (issue) begin
            rdata_reg <= mem[slot_reg];
            if (cur_present) begin
                mem[slot_reg] <= next_off_reg;
            end
        end
    end

    // walk control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walking_reg    <= 1'b0;
            written_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (ctrl.start && start_ok) begin
                walking_reg <= 1'b1;
            end else if (issue && slot_reg == SLOT_W'(SLOT_COUNT)) begin
                walking_reg <= 1'b0;
            end
            if (issue && cur_present) begin
                written_reg[slot_reg] <= 1'b1;
            end
            if (issue) begin
                pend_valid_reg <= 1'b1;
            end else if (load_now) begin
                pend_valid_reg <= 1'b0;
            end
            if (load_now) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (ctrl.start && start_ok) begin
            item_reg     <= item;
            slot_reg     <= SLOT_W'(1);
            next_off_reg <= POSITION_FLOATS;
        end else if (issue) begin
            slot_reg <= slot_reg + SLOT_W'(1);
            if (cur_present) begin
                next_off_reg <= next_off_reg + OFFSET_W'(slot_width(slot_reg));
            end
        end
        if (issue) begin
            pend_slot_reg    <= slot_reg;
            pend_present_reg <= cur_present;
            pend_written_reg <= written_reg[slot_reg];
            pend_off_reg     <= next_off_reg;
        end
        if (load_now) begin
            out_slot_reg    <= pend_slot_reg;
            out_offset_reg  <= pend_offset;
            out_present_reg <= pend_present_reg;
            out_stride_reg  <= item_reg.stride;
            out_float_reg   <= item_reg.float_count;
            out_bytes_reg   <= item_reg.byte_count;
            out_fits_reg    <= item_reg.fits;
            out_last_reg    <= (pend_slot_reg == SLOT_W'(SLOT_COUNT));
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_slot        = out_slot_reg;
    assign m_offset      = out_offset_reg;
    assign m_present     = out_present_reg;
    assign m_stride      = out_stride_reg;
    assign m_float_count = out_float_reg;
    assign m_byte_count  = out_bytes_reg;
    assign m_fits        = out_fits_reg;
    assign m_last        = out_last_reg;

    a_walk_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        issue && slot_reg == SLOT_W'(SLOT_COUNT) |=> !walking_reg)
        else $error("walk did not end after the last slot");

    a_stride: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_stride_reg == {out_float_reg, 2'b00})
        else $error("stride does not match float count");

    a_offset_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_present_reg |-> out_offset_reg < out_float_reg)
        else $error("placed offset outside the vertex");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_last_reg == (out_slot_reg == SLOT_W'(SLOT_COUNT)))
        else $error("last flag on wrong slot");

endmodule
`default_nettype wire
